@@ rtl/core/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/core/rlt_pkg.sv @@
// package: payload types and codes of the replication log table
`default_nettype none
package rlt_pkg;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned PAY_W = 64;
    localparam int unsigned TOT_W = 9;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_FETCH   = 2'd1;
    localparam logic [1:0] KIND_SIGN    = 2'd2;
    localparam logic [1:0] KIND_COMPACT = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOKEY = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [0:0] CFG_RETRY = 1'b0;
    localparam logic [0:0] CFG_SCAN  = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] entry_key;
        logic [PAY_W-1:0] entry_payload;
        logic             repl_ok;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] out_key;
        logic [PAY_W-1:0] out_payload;
        logic [TOT_W-1:0] entry_total;
        logic             last;
    } t_out;

    // flag word stored per entry
    typedef struct packed {
        logic       handed;
        logic       deleted;
        logic [2:0] retry;
    } t_flags;
endpackage
`default_nettype wire

@@ rtl/core/rlt_mem.sv @@
// entry memory: one write port, one registered read port
`default_nettype none
module rlt_mem #(
    parameter int unsigned AW = 8,
    parameter int unsigned DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [DW-1:0]      o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    // synchronous write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/replication_log_table_top.sv @@
// replication log table: sequencer around the entry memory
// Usage: one operation transaction enters on i_in_valid/o_in_ready with kind,
// key, payload and success bit. Results leave on o_out_valid/i_out_ready;
// each operation gives one result, except fetch which gives one per handed
// out entry (last marks the final one). One operation runs at a time.
// An add's result appears in the output register in the cycle after it is
// taken, so adds can follow each other every cycle while the receiver takes
// the results. Sign, fetch and compact visit each examined entry in a memory
// read state and then an examine state; compact also moves each entry down
// in a read state and then a write state. A limit check and a final result
// state come on top; the run time is set by the single read port of the
// entry memory; fetch examines at most 63 entries.
// Reset empties the table (used count zero) and restores retry limit 5 and
// scan limit 63; memory contents need no clearing.
// When the receiver stalls, the output register holds; fetch waits on an
// eligible entry until the register is free, and no new operation is taken
// while the register holds a result that is not being read.
`default_nettype none
module replication_log_table_top #(
    parameter int unsigned TABLE_DEPTH = 256,
    parameter int unsigned KEY_BITS    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rlt_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rlt_pkg::t_out      o_out,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [5:0]    i_cfg_data
);
    import rlt_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned DW = KEY_BITS + PAY_W + 5;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXAM, S_EMIT, S_CREAD, S_CMOVE, S_DONE
    } t_state;

    t_state           r_state;
    logic [2:0]       r_retry_lim;
    logic [5:0]       r_scan_lim;
    logic [CW-1:0]    r_used;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_lim;
    logic [CW-1:0]    r_run;
    logic [CW-1:0]    r_start;
    logic             r_found;
    logic [1:0]       r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic             r_succ;
    logic             r_any;
    t_out             r_pout;
    logic             r_ov;
    t_out             r_out;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [DW-1:0]    mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [DW-1:0]    mem_rdata;

    logic [KEY_BITS-1:0] rd_key;
    logic [PAY_W-1:0]    rd_pay;
    t_flags              rd_fl;
    t_flags              wr_fl;
    logic                elig;
    logic [CW-1:0]       next_idx;
    logic                in_fire;
    logic                fetch_take;
    logic                out_load;
    t_out                out_word;
    t_out                fetch_word;

    rlt_mem #(.AW(AW), .DW(DW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // field view of the read word
    assign rd_key   = mem_rdata[DW-1 -: KEY_BITS];
    assign rd_pay   = mem_rdata[5 +: PAY_W];
    assign rd_fl    = t_flags'(mem_rdata[4:0]);
    assign next_idx = r_idx + CW'(1);
    assign elig     = !rd_fl.handed && !rd_fl.deleted && (rd_fl.retry < r_retry_lim);

    // free slot for a result
    logic out_free;
    assign out_free    = !r_ov || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign fetch_take  = (r_state == S_EXAM) && (r_kind == KIND_FETCH) && elig && out_free;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // updated flags for sign
    always_comb begin
        wr_fl = rd_fl;
        if (r_succ) begin
            wr_fl.handed  = 1'b0;
            wr_fl.deleted = 1'b1;
        end else begin
            wr_fl.handed = 1'b0;
            if (rd_fl.retry != 3'd7) begin
                wr_fl.retry = rd_fl.retry + 3'd1;
            end
        end
    end

    // result word of a fetched entry
    always_comb begin
        fetch_word             = '0;
        fetch_word.status      = ST_OK;
        fetch_word.out_key     = KEY_W'(rd_key);
        fetch_word.out_payload = rd_pay;
        fetch_word.entry_total = TOT_W'(r_used);
    end

    // result word loaded into the output register
    always_comb begin
        out_load             = 1'b0;
        out_word             = '0;
        out_word.last        = 1'b1;
        out_word.entry_total = TOT_W'(r_used);
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_in.kind == KIND_ADD)) begin
                    out_load = 1'b1;
                    if (r_used < CW'(TABLE_DEPTH)) begin
                        out_word.entry_total = TOT_W'(r_used + CW'(1));
                    end else begin
                        out_word.status = ST_FULL;
                    end
                end
            end
            S_EXAM: begin
                // previous fetched entry leaves once another is found
                if (fetch_take && r_any) begin
                    out_load = 1'b1;
                    out_word = r_pout;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_kind == KIND_FETCH && r_any) begin
                        out_word      = r_pout;
                        out_word.last = 1'b1;
                    end else begin
                        if (r_kind == KIND_FETCH) out_word.status = ST_EMPTY;
                        if (r_kind == KIND_SIGN && !r_found) out_word.status = ST_NOKEY;
                        if (r_kind == KIND_COMPACT && r_found) begin
                            out_word.entry_total = TOT_W'(r_used - r_run);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                mem_we    = in_fire && (i_in.kind == KIND_ADD)
                            && (r_used < CW'(TABLE_DEPTH));
                mem_waddr = r_used[AW-1:0];
                mem_wdata = {i_in.entry_key[KEY_BITS-1:0], i_in.entry_payload, 5'd0};
            end
            S_EXAM: begin
                if (fetch_take) begin
                    mem_we    = 1'b1;
                    mem_wdata = {rd_key, rd_pay, 1'b1, rd_fl.deleted, rd_fl.retry};
                end else if (r_kind == KIND_SIGN && rd_key == r_key) begin
                    mem_we    = 1'b1;
                    mem_wdata = {rd_key, rd_pay, wr_fl};
                end
            end
            S_CREAD: begin
                mem_raddr = AW'(r_idx + r_run);
            end
            S_CMOVE: begin
                mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer, config and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_retry_lim <= 3'd5;
            r_scan_lim  <= 6'd63;
            r_used      <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RETRY) r_retry_lim <= i_cfg_data[2:0];
                else                          r_scan_lim  <= i_cfg_data;
            end
            // load a result or drain the held one
            if (out_load) begin
                r_ov  <= 1'b1;
                r_out <= out_word;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_kind  <= i_in.kind;
                        r_key   <= i_in.entry_key[KEY_BITS-1:0];
                        r_succ  <= i_in.repl_ok;
                        r_idx   <= '0;
                        r_any   <= 1'b0;
                        r_found <= 1'b0;
                        r_run   <= '0;
                        unique case (i_in.kind)
                            KIND_ADD: begin
                                if (r_used < CW'(TABLE_DEPTH)) begin
                                    r_used <= r_used + CW'(1);
                                end
                            end
                            KIND_FETCH: begin
                                r_lim   <= (32'(r_scan_lim) < 32'(r_used)) ?
                                           CW'(r_scan_lim) : r_used;
                                r_state <= S_READ;
                            end
                            KIND_SIGN: begin
                                r_lim   <= r_used;
                                r_state <= S_READ;
                            end
                            default: begin
                                r_lim   <= r_used;
                                r_state <= S_READ;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    // scan ends at the limit; a deleted run reaching the end needs no move
                    if (r_idx >= r_lim) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_EXAM;
                    end
                end
                S_EXAM: begin
                    if (r_kind == KIND_FETCH) begin
                        if (!elig) begin
                            r_idx <= next_idx; r_state <= S_READ;
                        end else if (fetch_take) begin
                            // hold back the entry until the next one or the end
                            r_pout <= fetch_word;
                            r_any  <= 1'b1;
                            r_idx  <= next_idx; r_state <= S_READ;
                        end
                    end else if (r_kind == KIND_SIGN) begin
                        if (rd_key == r_key) begin
                            r_found <= 1'b1; r_state <= S_DONE;
                        end else begin
                            r_idx <= next_idx; r_state <= S_READ;
                        end
                    end else begin
                        // compact: find first deleted, count the run, then move entries down
                        if (!r_found) begin
                            if (rd_fl.deleted) begin
                                r_found <= 1'b1; r_start <= r_idx; r_run <= CW'(1);
                            end
                            r_idx <= next_idx; r_state <= S_READ;
                        end else if (rd_fl.deleted) begin
                            r_run <= r_run + CW'(1);
                            r_idx <= next_idx; r_state <= S_READ;
                        end else begin
                            r_idx <= r_start; r_state <= S_CREAD;
                        end
                    end
                end
                S_CREAD: begin
                    if (r_idx + r_run >= r_used) r_state <= S_DONE;
                    else                         r_state <= S_CMOVE;
                end
                S_CMOVE: begin
                    r_idx <= next_idx; r_state <= S_CREAD;
                end
                default: begin
                    // S_DONE: final result
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (r_kind == KIND_COMPACT && r_found) begin
                            r_used <= r_used - r_run;
                        end
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/rlt_checker.sv @@
// port checker for the replication log table, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module rlt_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire rlt_pkg::t_in  i_in,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire rlt_pkg::t_out o_out
);
    import rlt_pkg::*;
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))
    `ASSERT_IMPL(a_total_range, i_clk, i_rst_n, o_out_valid, o_out.entry_total <= 9'd256)
    `ASSERT_IMPL(a_zero_key, i_clk, i_rst_n, o_out_valid && o_out.status != ST_OK, o_out.out_key == '0 && o_out.last)
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in))
endmodule

bind replication_log_table_top rlt_checker u_rlt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire

@@ test/tb_replication_log_table_top.sv @@
// testbench for the replication log table: directed table, limit and fill cases, then random operations
`timescale 1ns / 100ps
`default_nettype none
module tb_replication_log_table_top;
    import rlt_pkg::*;

    localparam int DEPTH = 256;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    t_in           i_in;
    logic          o_out_valid;
    logic          i_out_ready;
    t_out          o_out;
    logic          i_cfg_we;
    logic          i_cfg_index;
    logic [5:0]    i_cfg_data;

    replication_log_table_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow of the table
    logic [KEY_W-1:0] tbl_key [DEPTH];
    logic [PAY_W-1:0] tbl_pay [DEPTH];
    t_flags           tbl_flg [DEPTH];
    int               used_cnt;
    logic [2:0]       retry_lim;
    logic [5:0]       scan_lim;

    t_out result_queue [$];
    int   error_cnt;
    int   result_cnt;
    int   op_cnt;
    int   send_idle_pct;
    int   recv_stall_pct;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // time limit
    initial begin
        #40_000_000;
        $display("[replication_log_table_top] ERROR");
        $finish;
    end

    function automatic t_out mk_result(logic [1:0] st, logic [KEY_W-1:0] k,
                                       logic [PAY_W-1:0] p, logic lst);
        t_out r;
        r.status      = st;
        r.out_key     = k;
        r.out_payload = p;
        r.entry_total = used_cnt[TOT_W-1:0];
        r.last        = lst;
        return r;
    endfunction

    // table behavior: applies one operation and queues its results
    task automatic apply_table_op(input t_in op);
        int lim;
        int n;
        int start;
        int run;
        n = 0;
        case (op.kind)
            KIND_ADD: begin
                if (used_cnt >= DEPTH) begin
                    result_queue.push_back(mk_result(ST_FULL, '0, '0, 1'b1));
                end else begin
                    tbl_key[used_cnt] = op.entry_key;
                    tbl_pay[used_cnt] = op.entry_payload;
                    tbl_flg[used_cnt] = '0;
                    used_cnt++;
                    result_queue.push_back(mk_result(ST_OK, '0, '0, 1'b1));
                end
            end
            KIND_FETCH: begin
                lim = (scan_lim < used_cnt) ? scan_lim : used_cnt;
                for (int i = 0; i < lim; i++) begin
                    if (tbl_flg[i].handed || tbl_flg[i].deleted) continue;
                    if (tbl_flg[i].retry >= retry_lim) continue;
                    tbl_flg[i].handed = 1'b1;
                    result_queue.push_back(mk_result(ST_OK, tbl_key[i], tbl_pay[i], 1'b0));
                    n++;
                end
                if (n == 0)
                    result_queue.push_back(mk_result(ST_EMPTY, '0, '0, 1'b1));
                else
                    result_queue[$].last = 1'b1;
            end
            KIND_SIGN: begin
                for (int i = 0; i < used_cnt; i++) begin
                    if (tbl_key[i] == op.entry_key) begin
                        tbl_flg[i].handed = 1'b0;
                        if (op.repl_ok)
                            tbl_flg[i].deleted = 1'b1;
                        else if (tbl_flg[i].retry != 3'd7)
                            tbl_flg[i].retry++;
                        n = 1;
                        break;
                    end
                end
                result_queue.push_back(mk_result(n ? ST_OK : ST_NOKEY, '0, '0, 1'b1));
            end
            default: begin
                start = used_cnt;
                run = 0;
                for (int i = 0; i < used_cnt; i++)
                    if (tbl_flg[i].deleted) begin
                        start = i;
                        break;
                    end
                while (start + run < used_cnt && tbl_flg[start + run].deleted) run++;
                for (int j = start; j + run < used_cnt; j++) begin
                    tbl_key[j] = tbl_key[j + run];
                    tbl_pay[j] = tbl_pay[j + run];
                    tbl_flg[j] = tbl_flg[j + run];
                end
                used_cnt -= run;
                result_queue.push_back(mk_result(ST_OK, '0, '0, 1'b1));
            end
        endcase
    endtask

    // send one operation transaction; valid drops only when idling
    task automatic send_op(input t_in op);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= op;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        apply_table_op(op);
        op_cnt++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        while (result_queue.size() != 0) @(negedge i_clk);
        repeat (2 * DEPTH + 20) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [5:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RETRY) retry_lim = val[2:0];
        else scan_lim = val;
        @(negedge i_clk);
    endtask

    // receiver stall
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_cnt++;
            if (result_queue.size() == 0) begin
                $error("result transaction with nothing expected");
                error_cnt++;
            end else begin
                want = result_queue.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_out.status);
                    error_cnt++;
                end
                if (o_out.out_key !== want.out_key) begin
                    $error("out_key exp %h got %h", want.out_key, o_out.out_key);
                    error_cnt++;
                end
                if (o_out.out_payload !== want.out_payload) begin
                    $error("out_payload exp %h got %h", want.out_payload, o_out.out_payload);
                    error_cnt++;
                end
                if (o_out.entry_total !== want.entry_total) begin
                    $error("entry_total exp %0d got %0d", want.entry_total,
                           o_out.entry_total);
                    error_cnt++;
                end
                if (o_out.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, o_out.last);
                    error_cnt++;
                end
            end
        end
    end

    function automatic t_in mk_op(logic [1:0] k, logic [KEY_W-1:0] key,
                                  logic [PAY_W-1:0] pay, logic ok);
        t_in op;
        op.kind          = k;
        op.entry_key     = key;
        op.entry_payload = pay;
        op.repl_ok       = ok;
        return op;
    endfunction

    // key among those in use, or a fresh one now and then
    function automatic logic [KEY_W-1:0] pick_key();
        if (used_cnt > 0 && $urandom_range(9) < 8)
            return tbl_key[$urandom_range(used_cnt - 1)];
        return KEY_W'($urandom());
    endfunction

    // directed table: operation plus typed-in status and total where obvious
    typedef struct {
        t_in        op;
        logic       has_want;
        logic [1:0] want_status;
        int         want_total;
    } t_row;

    t_row dir_rows [$];

    task automatic run_random(input int n_ops);
        int r;
        for (int i = 0; i < n_ops; i++) begin
            r = $urandom_range(99);
            if (r < 40)
                send_op(mk_op(KIND_ADD, KEY_W'($urandom()),
                              {$urandom(), $urandom()}, 1'($urandom_range(1))));
            else if (r < 60)
                send_op(mk_op(KIND_FETCH, $urandom(), {$urandom(), $urandom()},
                              1'($urandom_range(1))));
            else if (r < 88)
                send_op(mk_op(KIND_SIGN, pick_key(), {$urandom(), $urandom()},
                              $urandom_range(3) != 0));
            else
                send_op(mk_op(KIND_COMPACT, $urandom(), {$urandom(), $urandom()},
                              1'($urandom_range(1))));
        end
    endtask

    initial begin
        t_row row;
        error_cnt      = 0;
        result_cnt     = 0;
        op_cnt         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        used_cnt       = 0;
        retry_lim      = 3'd5;
        scan_lim       = 6'd63;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        i_out_ready    = 1'b1;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_RETRY;
        i_cfg_data     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        dir_rows.push_back('{mk_op(KIND_FETCH, '0, '0, 1'b0), 1'b1, ST_EMPTY, 0});
        dir_rows.push_back('{mk_op(KIND_SIGN, '1, '0, 1'b1), 1'b1, ST_NOKEY, 0});
        dir_rows.push_back('{mk_op(KIND_COMPACT, '0, '0, 1'b0), 1'b1, ST_OK, 0});
        dir_rows.push_back('{mk_op(KIND_ADD, '0, '0, 1'b0), 1'b1, ST_OK, 1});
        dir_rows.push_back('{mk_op(KIND_ADD, '1, '1, 1'b1), 1'b1, ST_OK, 2});
        dir_rows.push_back('{mk_op(KIND_ADD, 32'h5555_aaaa, 64'haaaa_5555_0f0f_f0f0, 1'b0),
                             1'b1, ST_OK, 3});
        dir_rows.push_back('{mk_op(KIND_ADD, 32'h5555_aaaa, 64'h1, 1'b0), 1'b1, ST_OK, 4});
        dir_rows.push_back('{mk_op(KIND_FETCH, '0, '0, 1'b0), 1'b0, ST_OK, 0});
        dir_rows.push_back('{mk_op(KIND_FETCH, '0, '0, 1'b0), 1'b1, ST_EMPTY, 4});
        dir_rows.push_back('{mk_op(KIND_SIGN, 32'h5555_aaaa, '0, 1'b0), 1'b1, ST_OK, 4});
        dir_rows.push_back('{mk_op(KIND_SIGN, 32'h5555_aaaa, '0, 1'b0), 1'b1, ST_OK, 4});
        dir_rows.push_back('{mk_op(KIND_FETCH, '0, '0, 1'b0), 1'b0, ST_OK, 0});
        dir_rows.push_back('{mk_op(KIND_SIGN, '1, '0, 1'b1), 1'b1, ST_OK, 4});
        dir_rows.push_back('{mk_op(KIND_SIGN, '0, '0, 1'b1), 1'b1, ST_OK, 4});
        dir_rows.push_back('{mk_op(KIND_SIGN, 32'h1234, '0, 1'b1), 1'b1, ST_NOKEY, 4});
        dir_rows.push_back('{mk_op(KIND_COMPACT, '0, '0, 1'b0), 1'b1, ST_OK, 2});
        dir_rows.push_back('{mk_op(KIND_COMPACT, '0, '0, 1'b0), 1'b1, ST_OK, 2});
        dir_rows.push_back('{mk_op(KIND_FETCH, '0, '0, 1'b0), 1'b0, ST_OK, 0});
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_op(row.op);
            if (row.has_want && result_queue[$].status !== row.want_status) begin
                $error("directed row %0d status exp %0d got %0d", i, row.want_status,
                       result_queue[$].status);
                error_cnt++;
            end
            if (row.has_want && result_queue[$].entry_total !== TOT_W'(row.want_total)) begin
                $error("directed row %0d entry_total exp %0d got %0d", i, row.want_total,
                       result_queue[$].entry_total);
                error_cnt++;
            end
        end
        wait_drained();

        // zero limits: nothing eligible, nothing examined
        write_cfg(CFG_RETRY, 6'd0);
        send_op(mk_op(KIND_FETCH, '0, '0, 1'b0));
        wait_drained();
        write_cfg(CFG_RETRY, 6'd7);
        write_cfg(CFG_SCAN, 6'd0);
        send_op(mk_op(KIND_FETCH, '0, '0, 1'b0));
        wait_drained();
        write_cfg(CFG_SCAN, 6'd63);

        // fill the table to full and beyond
        while (used_cnt < DEPTH)
            send_op(mk_op(KIND_ADD, $urandom(), {$urandom(), $urandom()}, 1'b0));
        send_op(mk_op(KIND_ADD, '1, '1, 1'b1));
        send_op(mk_op(KIND_FETCH, '0, '0, 1'b0));
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_op(mk_op(KIND_SIGN, tbl_key[$urandom_range(used_cnt - 1)], '0, 1'b1));
        send_op(mk_op(KIND_COMPACT, '0, '0, 1'b0));
        send_op(mk_op(KIND_COMPACT, '0, '0, 1'b0));
        wait_drained();

        // random phases under several idling mixes and limit settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            write_cfg(CFG_RETRY, 6'($urandom_range(7, 1)));
            write_cfg(CFG_SCAN, (ph == 1) ? 6'd1 : 6'($urandom_range(63, 1)));
            run_random(33);
            wait_drained();
        end
        write_cfg(CFG_RETRY, 6'd1);
        write_cfg(CFG_SCAN, 6'd63);

        $display("ran %0d operations, checked %0d results, retry and scan limits swept",
                 op_cnt, result_cnt);
        if (error_cnt == 0 && result_queue.size() == 0)
            $display("[replication_log_table_top] OK");
        else
            $display("[replication_log_table_top] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/rlt_pkg.sv
rtl/core/rlt_mem.sv
rtl/core/replication_log_table_top.sv
rtl/core/rlt_checker.sv
test/tb_replication_log_table_top.sv
